/* rtl/spq_pkg.sv */
package spq_pkg;

  // Queue depth and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int DATA_W   = 32;
  localparam int KEY_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One stored entry
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [KEY_W-1:0]  key;
  } entry_t;

  // Broadcast command to every cell
  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

/* rtl/spq_if.sv */
// Request channel: operation plus insert payload
interface spq_req_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic signed [spq_pkg::DATA_W-1:0]  new_data;
  logic signed [spq_pkg::KEY_W-1:0]   new_priority;

  modport source (output valid, operation, new_data, new_priority, input ready);
  modport sink   (input valid, operation, new_data, new_priority, output ready);
endinterface

// Response channel: one result per request
interface spq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [spq_pkg::DATA_W-1:0]   out_data;
  logic        [spq_pkg::STATUS_W-1:0] status;
  logic        [spq_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, out_data, status, entry_count, input ready);
  modport sink   (input valid, out_data, status, entry_count, output ready);
endinterface

/* rtl/spq_cell.sv */
// One slot of the sorted array. Keeps its entry, takes the new item,
// takes the left neighbor's entry (insert shift) or the right one (remove).
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::entry_t    new_entry,
  input  logic               occupied,
  input  logic               left_le,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               le,
  output spq_pkg::entry_t    entry
);

  // This slot stays ahead of the new item
  assign le = occupied && (entry.key <= cmd.key);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!le) begin
        if (left_le) begin
          entry <= new_entry;
        end else begin
          entry <= left_entry;
        end
      end
    end else if (cmd.remove) begin
      entry <= right_entry;
    end
  end

endmodule

/* rtl/sorted_priority_queue.sv */
// Channel | Dir | Payload
// req     | in  | operation, new_data, new_priority
// rsp     | out | out_data, status, entry_count
//
// One item per cycle while req.ready is high: every cell compares its key with the new key and
// moves in the same cycle, so the row of cells sets the rate.
// The result is registered and shows in the cycle after the item is taken.
// req.ready is low only while a result waits and rsp.ready is low.
// Reset clears the entry count and the result valid flag; slot contents are kept.
module sorted_priority_queue (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  localparam int N = spq_pkg::CAPACITY;

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  spq_pkg::cell_cmd_t        cmd;
  spq_pkg::entry_t           new_entry;
  spq_pkg::entry_t           entries [N];
  logic                      le [N];
  logic [spq_pkg::CNT_W+spq_pkg::COUNT_W-1:0] count_wide;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == spq_pkg::CNT_W'(N));
  assign empty     = (count == '0);

  // Command broadcast to the row
  assign cmd.insert = accept && (req.operation == spq_pkg::OP_INSERT) && !full;
  assign cmd.remove = accept && (req.operation == spq_pkg::OP_REMOVE) && !empty;
  assign cmd.key    = req.new_priority;
  assign new_entry.data = req.new_data;
  assign new_entry.key  = req.new_priority;

  // Row of cells, slot 0 leaves first
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_le;
    logic            occ;

    assign occ = (spq_pkg::CNT_W'(i) < count);
    if (i == 0) begin : g_first
      assign left_le = 1'b1;
      assign left_e  = new_entry;
    end else begin : g_mid
      assign left_le = le[i-1];
      assign left_e  = entries[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_entry  (new_entry),
      .occupied   (occ),
      .left_le    (left_le),
      .left_entry (left_e),
      .right_entry(right_e),
      .le         (le[i]),
      .entry      (entries[i])
    );
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + 1'b1;
    end else if (cmd.remove) begin
      count_next = count - 1'b1;
    end
  end

  assign count_wide = {{spq_pkg::COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_data    <= cmd.remove ? entries[0].data : '0;
      rsp.entry_count <= count_wide[spq_pkg::COUNT_W-1:0];
      if (req.operation == spq_pkg::OP_INSERT) begin
        rsp.status <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end else begin
        rsp.status <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == spq_pkg::OP_REMOVE && empty)
      |=> (rsp.status == spq_pkg::ST_EMPTY && count == '0))
    else $error("remove from empty queue misreported");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> (count == $past(count) + 1'b1 && rsp.status == spq_pkg::ST_OK))
    else $error("insert did not add an entry");

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One request item plus a flag that holds it back until every outstanding result has been received
  typedef struct {
    logic                              operation;
    logic signed [spq_pkg::DATA_W-1:0] data;
    logic signed [spq_pkg::KEY_W-1:0]  key;
    bit                                wait_drain;
  } op_item_t;

  typedef struct {
    logic signed [spq_pkg::DATA_W-1:0] out_data;
    logic [spq_pkg::STATUS_W-1:0]      status;
    logic [spq_pkg::COUNT_W-1:0]       entry_count;
  } result_t;

  logic clk = 1'b0;
  logic rst;

  spq_req_if req ();
  spq_rsp_if rsp ();

  sorted_priority_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shadow copy of the sorted entries
  logic signed [spq_pkg::DATA_W-1:0] shadow_data [spq_pkg::CAPACITY];
  logic signed [spq_pkg::KEY_W-1:0]  shadow_key  [spq_pkg::CAPACITY];
  int                                shadow_count = 0;

  op_item_t pending_ops[$];
  result_t  expected_results[$];

  int  accepted_ops = 0;
  int  issued_ops   = 0;
  int  mismatches   = 0;
  int  send_gap;
  int  recv_stall;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;

  always #5 clk = ~clk;

  // Gap length: mostly short, a few long, none during calm stretches
  function automatic int draw_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Apply one item to the shadow queue and return the result it must give
  function automatic result_t queue_update(input op_item_t it);
    result_t res;
    int      pos;
    int      i;
    res.out_data = '0;
    res.status   = spq_pkg::ST_OK;
    if (it.operation == spq_pkg::OP_INSERT) begin
      if (shadow_count >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // new entry goes behind every key less than or equal to it
        pos = 0;
        while (pos < shadow_count && shadow_key[pos] <= it.key) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_key[i]  = shadow_key[i-1];
        end
        shadow_data[pos] = it.data;
        shadow_key[pos]  = it.key;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.out_data = shadow_data[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_data[i-1] = shadow_data[i];
          shadow_key[i-1]  = shadow_key[i];
        end
        shadow_count--;
      end
    end
    res.entry_count = shadow_count[spq_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic void add_op(input logic op,
                                 input logic signed [spq_pkg::DATA_W-1:0] data,
                                 input logic signed [spq_pkg::KEY_W-1:0] key,
                                 input bit hold);
    op_item_t it;
    it.operation  = op;
    it.data       = data;
    it.key        = key;
    it.wait_drain = hold;
    pending_ops.push_back(it);
    issued_ops++;
  endfunction

  // Request driver: predicts on acceptance, then presents the next item
  always @(posedge clk) begin
    op_item_t cur;
    op_item_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (req.valid && req.ready) begin
        cur.operation  = req.operation;
        cur.data       = req.new_data;
        cur.key        = req.new_priority;
        cur.wait_drain = 1'b0;
        expected_results.push_back(queue_update(cur));
        accepted_ops++;
      end
      if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          req.valid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].wait_drain &&
                       (expected_results.size() > 0 || (req.valid && req.ready)))) begin
          nxt = pending_ops.pop_front();
          req.valid        <= 1'b1;
          req.operation    <= nxt.operation;
          req.new_data     <= nxt.data;
          req.new_priority <= nxt.key;
          send_gap         <= draw_gap(send_calm);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares against the oldest expectation, stalls at random
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rsp.ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: out_data=%0d status=%0d entry_count=%0d",
                     rsp.out_data, rsp.status, rsp.entry_count);
        end else begin
          want = expected_results.pop_front();
          if (rsp.out_data !== want.out_data || rsp.status !== want.status ||
              rsp.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: out_data exp %0d got %0d, status exp %0d got %0d,",
                        " count exp %0d got %0d"},
                       want.out_data, rsp.out_data, want.status, rsp.status,
                       want.entry_count, rsp.entry_count);
          end
        end
      end
      if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
      if (recv_stall > 0) begin
        rsp.ready  <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall <= draw_gap(recv_calm);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int  mode_left;
    int  insert_pct;
    int  k;
    logic signed [spq_pkg::KEY_W-1:0] key;
    rst = 1'b1;

    // directed: empty remove, extreme values, ties including ties with the tail
    add_op(spq_pkg::OP_REMOVE, 32'sd0, 16'sd0, 1'b0);
    add_op(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'sh7FFF, 1'b0);
    add_op(spq_pkg::OP_INSERT, 32'h8000_0000, 16'sh8000, 1'b0);
    add_op(spq_pkg::OP_INSERT, 32'h0000_0000, 16'sd0, 1'b0);
    add_op(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'sd0, 1'b0);
    add_op(spq_pkg::OP_INSERT, 32'h1234_5678, 16'sd0, 1'b0);
    add_op(spq_pkg::OP_INSERT, 32'h0000_0005, 16'sh7FFF, 1'b0);
    add_op(spq_pkg::OP_INSERT, 32'h0000_0007, -16'sd1, 1'b0);
    for (k = 0; k < 7; k++)
      add_op(spq_pkg::OP_REMOVE, $urandom, spq_pkg::KEY_W'($urandom), 1'b0);
    add_op(spq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 16'shFFFF, 1'b0);

    // random: fill, drain and balanced stretches so full and empty come up often
    mode_left  = 0;
    insert_pct = 50;
    for (k = 0; k < 1000; k++) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 60);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      mode_left--;
      // narrow key range makes ties common
      if ($urandom_range(0, 1) == 0) key = spq_pkg::KEY_W'($urandom_range(0, 7) - 4);
      else key = spq_pkg::KEY_W'($urandom);
      add_op(($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE,
             $urandom, key, (k == 0 || k == 500));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (accepted_ops < issued_ops) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/testbench.sv
